[src/srbe_pkg.sv]
// ----------------------------------------------------------------------------
// srbe_pkg: shared types and constants for the source rate blacklist engine
// Table depth, codes for mode and register index, and the structs that the
// controller and the row of table cells exchange.
// ----------------------------------------------------------------------------
package srbe_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PURGE_W       = 9;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // item modes
    localparam logic [1:0] MODE_DETECT = 2'd0;
    localparam logic [1:0] MODE_FILTER = 2'd1;
    localparam logic [1:0] MODE_PURGE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_PURGE     = 2'd2;

    // command broadcast to every cell while a token travels the row
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] ip;
        logic [31:0] now;
        logic        purge_go;
        logic [31:0] purge_s;
    } bcast_t;

    // running search results handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             s_hit;
        logic [IDX_W-1:0] s_idx;
        logic [31:0]      s_cnt;
        logic [31:0]      s_ws;
        logic             l_hit;
        logic [IDX_W-1:0] l_idx;
        logic             s_free;
        logic [IDX_W-1:0] s_free_idx;
        logic             l_free;
        logic [IDX_W-1:0] l_free_idx;
        logic             m_valid;
        logic [IDX_W-1:0] m_idx;
        logic [31:0]      m_cnt;
        logic [PURGE_W-1:0] purged;
    } token_t;

    // table write broadcast from the controller
    typedef struct packed {
        logic             s_we;
        logic [IDX_W-1:0] s_idx;
        logic [31:0]      s_addr;
        logic [31:0]      s_cnt;
        logic [31:0]      s_ws;
        logic             l_we;
        logic [IDX_W-1:0] l_idx;
        logic [31:0]      l_addr;
        logic [31:0]      l_time;
    } wcmd_t;

endpackage

[src/srbe_in_if.sv]
// ----------------------------------------------------------------------------
// srbe_in_if: input item channel
// Valid/ready channel carrying one detect, filter or purge item per beat.
// ----------------------------------------------------------------------------
interface srbe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] source_ip;
    logic [31:0] now_seconds;

    modport source (output valid, mode, source_ip, now_seconds, input ready);
    modport sink   (input valid, mode, source_ip, now_seconds, output ready);
endinterface

[src/srbe_out_if.sv]
// ----------------------------------------------------------------------------
// srbe_out_if: result channel
// Valid/ready channel carrying one result beat per accepted item.
// ----------------------------------------------------------------------------
interface srbe_out_if;
    logic       valid;
    logic       ready;
    logic       blocked;
    logic       listed_now;
    logic       list_full;
    logic       evicted;
    logic [8:0] purged_count;

    modport source (output valid, blocked, listed_now, list_full, evicted, purged_count,
                    input ready);
    modport sink   (input valid, blocked, listed_now, list_full, evicted, purged_count,
                    output ready);
endinterface

[src/srbe_cell.sv]
// ----------------------------------------------------------------------------
// srbe_cell: one stats entry and one blacklist entry
// Compares its entries against the broadcast command when the token passes,
// folds its result into the token and hands it to the next cell.
// ----------------------------------------------------------------------------
module srbe_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [srbe_pkg::IDX_W-1:0] cell_idx,
    input  srbe_pkg::bcast_t       bc,
    input  srbe_pkg::wcmd_t        wc,
    input  srbe_pkg::token_t       tok_i,
    output srbe_pkg::token_t       tok_o
);
    import srbe_pkg::*;

    logic        stat_valid_reg;
    logic [31:0] stat_addr_reg;
    logic [31:0] stat_cnt_reg;
    logic [31:0] stat_ws_reg;
    logic        list_valid_reg;
    logic [31:0] list_addr_reg;
    logic [31:0] list_time_reg;
    token_t      tok_reg;
    token_t      tok_next;

    logic hit_s, hit_l, kill, s_wr, l_wr;
    logic [31:0] age;

    // local compares
    assign hit_s = stat_valid_reg && (stat_addr_reg == bc.ip);
    assign hit_l = list_valid_reg && (list_addr_reg == bc.ip);
    assign age   = bc.now - list_time_reg;
    assign kill  = tok_i.valid && (bc.mode == MODE_PURGE) && bc.purge_go
                   && list_valid_reg && (age > bc.purge_s);
    assign s_wr  = wc.s_we && (wc.s_idx == cell_idx);
    assign l_wr  = wc.l_we && (wc.l_idx == cell_idx);

    // fold this cell into the token
    always_comb
    begin
        tok_next = tok_i;
        if (!tok_i.s_hit && hit_s)
        begin
            tok_next.s_hit = 1'b1;
            tok_next.s_idx = cell_idx;
            tok_next.s_cnt = stat_cnt_reg;
            tok_next.s_ws  = stat_ws_reg;
        end
        if (!tok_i.l_hit && hit_l)
        begin
            tok_next.l_hit = 1'b1;
            tok_next.l_idx = cell_idx;
        end
        if (!tok_i.s_free && !stat_valid_reg)
        begin
            tok_next.s_free     = 1'b1;
            tok_next.s_free_idx = cell_idx;
        end
        if (!tok_i.l_free && !list_valid_reg)
        begin
            tok_next.l_free     = 1'b1;
            tok_next.l_free_idx = cell_idx;
        end
        // strict less keeps the lowest index on ties
        if (stat_valid_reg && (!tok_i.m_valid || stat_cnt_reg < tok_i.m_cnt))
        begin
            tok_next.m_valid = 1'b1;
            tok_next.m_idx   = cell_idx;
            tok_next.m_cnt   = stat_cnt_reg;
        end
        if (kill)
            tok_next.purged = tok_i.purged + PURGE_W'(1);
    end

    // token stage and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid  <= 1'b0;
            stat_valid_reg <= 1'b0;
            list_valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (s_wr)
                stat_valid_reg <= 1'b1;
            if (kill)
                list_valid_reg <= 1'b0;
            else if (l_wr)
                list_valid_reg <= 1'b1;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (s_wr)
        begin
            stat_addr_reg <= wc.s_addr;
            stat_cnt_reg  <= wc.s_cnt;
            stat_ws_reg   <= wc.s_ws;
        end
        if (l_wr)
        begin
            list_addr_reg <= wc.l_addr;
            list_time_reg <= wc.l_time;
        end
    end

    assign tok_o = tok_reg;

endmodule

[src/srbe_chain.sv]
// ----------------------------------------------------------------------------
// srbe_chain: row of table cells
// The token enters cell 0 and passes through one register in each cell before it leaves the last cell.
// ----------------------------------------------------------------------------
module srbe_chain (
    input  logic             clk,
    input  logic             rst_n,
    input  srbe_pkg::bcast_t bc,
    input  srbe_pkg::wcmd_t  wc,
    input  srbe_pkg::token_t tok_in,
    output srbe_pkg::token_t tok_out
);
    import srbe_pkg::*;

    token_t link [TABLE_ENTRIES+1];

    assign link[0] = tok_in;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        srbe_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .bc       (bc),
            .wc       (wc),
            .tok_i    (link[g]),
            .tok_o    (link[g+1])
        );
    end

    assign tok_out = link[TABLE_ENTRIES];

endmodule

[src/source_rate_blacklist_engine_core.sv]
// Sequence: an accepted item passes the states start, wait (the search token crosses the row,
// one cell per cycle), calc, apply and done; detect or filter with address zero and the unused
// mode go straight from idle to done. The result beat is registered as the item leaves done.
// Flow: one item at a time; a new item is taken only once the last has left done. A result
// still waiting on the sink holds the next result, and so the next item, for as long as it waits.
// Reset: all table entries invalid, registers at their defaults, last purge time 0.
// ----------------------------------------------------------------------------
// source_rate_blacklist_engine_core: per-source rate limiter with blacklist
// Controller that launches a search token through the cell row, decides the
// table update and returns one result beat per item.
// ----------------------------------------------------------------------------
module source_rate_blacklist_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    srbe_in_if.sink     in_ch,
    srbe_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import srbe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] thr_reg, win_reg, purge_s_reg, purge_mark_reg;
    logic [1:0]  mode_reg;
    logic [31:0] ip_reg, now_reg;
    logic        purge_go_reg;
    token_t      res_reg;
    logic        exp_reg;
    logic [31:0] inc_reg;
    wcmd_t       wc_reg, wc_next;

    logic        out_valid_reg;
    logic        blocked_reg, listed_reg, full_reg, evicted_reg;
    logic [8:0]  purged_reg;
    logic        out_blocked_reg, out_listed_reg, out_full_reg, out_evicted_reg;
    logic [8:0]  out_purged_reg;
    logic        r_blocked, r_listed, r_full, r_evicted;
    logic [8:0]  r_purged;

    logic        accept, trivial, purge_go_in, out_free;
    bcast_t      bc;
    token_t      tok_in, tok_out;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign trivial     = (in_ch.mode == MODE_UNUSED)
                         || ((in_ch.mode != MODE_PURGE) && (in_ch.source_ip == 32'd0));
    assign purge_go_in = (purge_s_reg != ALL_ONES)
                         && ((in_ch.now_seconds - purge_mark_reg) >= purge_s_reg);
    assign out_free    = !out_valid_reg || out_ch.ready;

    // broadcast and token launch
    always_comb
    begin
        bc.mode     = mode_reg;
        bc.ip       = ip_reg;
        bc.now      = now_reg;
        bc.purge_go = purge_go_reg;
        bc.purge_s  = purge_s_reg;
        tok_in       = '0;
        tok_in.valid = (state_reg == S_START);
    end

    srbe_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .bc      (bc),
        .wc      (wc_reg),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    // decide table update and result
    always_comb
    begin
        wc_next   = '0;
        r_blocked = 1'b0;
        r_listed  = 1'b0;
        r_full    = 1'b0;
        r_evicted = 1'b0;
        r_purged  = 9'd0;
        wc_next.s_addr = ip_reg;
        wc_next.s_ws   = now_reg;
        wc_next.s_cnt  = 32'd1;
        wc_next.l_addr = ip_reg;
        wc_next.l_time = now_reg;
        case (mode_reg)
            MODE_DETECT:
            begin
                wc_next.s_we = 1'b1;
                if (!res_reg.s_hit)
                begin
                    if (res_reg.s_free)
                        wc_next.s_idx = res_reg.s_free_idx;
                    else
                    begin
                        wc_next.s_idx = res_reg.m_idx;
                        r_evicted     = 1'b1;
                    end
                end
                else
                begin
                    wc_next.s_idx = res_reg.s_idx;
                    if (!exp_reg)
                    begin
                        wc_next.s_ws  = res_reg.s_ws;
                        wc_next.s_cnt = inc_reg;
                        if (inc_reg >= thr_reg)
                        begin
                            if (res_reg.l_hit || res_reg.l_free)
                            begin
                                wc_next.l_we  = 1'b1;
                                wc_next.l_idx = res_reg.l_hit ? res_reg.l_idx
                                                              : res_reg.l_free_idx;
                                wc_next.s_cnt = 32'd0;
                                r_listed      = 1'b1;
                            end
                            else
                                r_full = 1'b1;
                        end
                    end
                end
            end
            MODE_FILTER: r_blocked = res_reg.l_hit;
            MODE_PURGE:  r_purged  = res_reg.purged;
            default:     r_purged  = 9'd0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = trivial ? S_DONE : S_START;
            S_START: state_next = S_WAIT;
            S_WAIT:  if (tok_out.valid) state_next = S_CALC;
            S_CALC:  state_next = S_APPLY;
            S_APPLY: state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= 32'd100;
            win_reg        <= 32'd1;
            purge_s_reg    <= ALL_ONES;
            purge_mark_reg <= 32'd0;
            wc_reg.s_we    <= 1'b0;
            wc_reg.l_we    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr_reg     <= cfg_wdata;
                    REG_WINDOW:    win_reg     <= cfg_wdata;
                    REG_PURGE:     purge_s_reg <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (state_reg == S_APPLY)
                wc_reg <= wc_next;
            else
            begin
                wc_reg.s_we <= 1'b0;
                wc_reg.l_we <= 1'b0;
            end
            if (state_reg == S_APPLY && mode_reg == MODE_PURGE && purge_go_reg)
                purge_mark_reg <= now_reg;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= in_ch.mode;
            ip_reg       <= in_ch.source_ip;
            now_reg      <= in_ch.now_seconds;
            purge_go_reg <= purge_go_in;
            blocked_reg  <= 1'b0;
            listed_reg   <= 1'b0;
            full_reg     <= 1'b0;
            evicted_reg  <= 1'b0;
            purged_reg   <= 9'd0;
        end
        if (state_reg == S_WAIT && tok_out.valid)
            res_reg <= tok_out;
        if (state_reg == S_CALC)
        begin
            exp_reg <= (now_reg - res_reg.s_ws) > win_reg;
            inc_reg <= (res_reg.s_cnt == ALL_ONES) ? ALL_ONES : res_reg.s_cnt + 32'd1;
        end
        if (state_reg == S_APPLY)
        begin
            blocked_reg <= r_blocked;
            listed_reg  <= r_listed;
            full_reg    <= r_full;
            evicted_reg <= r_evicted;
            purged_reg  <= r_purged;
        end
        // result beat register, loaded only once the previous beat has left
        if (state_reg == S_DONE && out_free)
        begin
            out_blocked_reg <= blocked_reg;
            out_listed_reg  <= listed_reg;
            out_full_reg    <= full_reg;
            out_evicted_reg <= evicted_reg;
            out_purged_reg  <= purged_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.blocked      = out_blocked_reg;
    assign out_ch.listed_now   = out_listed_reg;
    assign out_ch.list_full    = out_full_reg;
    assign out_ch.evicted      = out_evicted_reg;
    assign out_ch.purged_count = out_purged_reg;

endmodule

[sim/srbe_checker.sv]
// ----------------------------------------------------------------------------
// srbe_checker: scoreboard for the source rate blacklist engine
// Watches the item and result channels and the register write port. It keeps
// its own copy of the stats table and blacklist to predict every result beat,
// then compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module srbe_checker (
    input  logic        clk,
    input  logic        rst_n,
    srbe_in_if          in_ch,
    srbe_out_if         out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          errors,
    output int          pending
);
    import srbe_pkg::*;

    typedef struct {
        logic       blocked;
        logic       listed_now;
        logic       list_full;
        logic       evicted;
        logic [8:0] purged_count;
    } verdict_t;

    // shadow registers
    logic [31:0] threshold_r;
    logic [31:0] window_r;
    logic [31:0] purge_r;

    // shadow tables
    bit          sv_valid [TABLE_ENTRIES];
    logic [31:0] sv_addr  [TABLE_ENTRIES];
    logic [31:0] sv_count [TABLE_ENTRIES];
    logic [31:0] sv_start [TABLE_ENTRIES];
    bit          bl_valid [TABLE_ENTRIES];
    logic [31:0] bl_addr  [TABLE_ENTRIES];
    logic [31:0] bl_time  [TABLE_ENTRIES];
    logic [31:0] purge_mark;
    int          stats_used;

    verdict_t expected_q [$];

    assign pending = expected_q.size();

    function automatic int find_blacklisted(logic [31:0] ip);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (bl_valid[i] && bl_addr[i] == ip)
                return i;
        return -1;
    endfunction

    // detect packet: count update, eviction and blacklisting
    function automatic void count_packet(logic [31:0] ip, logic [31:0] now,
                                         ref verdict_t v);
        int s;
        int best;
        int slot;
        s = -1;
        best = -1;
        slot = -1;
        if (ip == 0)
            return;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (s < 0 && sv_valid[i] && sv_addr[i] == ip)
                s = i;
        if (s < 0) begin
            if (stats_used >= TABLE_ENTRIES) begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (sv_valid[i] && (best < 0 || sv_count[i] < sv_count[best]))
                        best = i;
                if (best >= 0) begin
                    sv_valid[best] = 0;
                    if (stats_used > 0)
                        stats_used--;
                    v.evicted = 1;
                end
            end
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && !sv_valid[i])
                    slot = i;
            if (slot >= 0) begin
                sv_valid[slot] = 1;
                sv_addr[slot]  = ip;
                sv_count[slot] = 1;
                sv_start[slot] = now;
                stats_used++;
            end
            return;
        end
        if (32'(now - sv_start[s]) > window_r) begin
            sv_count[s] = 1;
            sv_start[s] = now;
            return;
        end
        if (sv_count[s] != ALL_ONES)
            sv_count[s]++;
        if (sv_count[s] < threshold_r)
            return;
        slot = find_blacklisted(ip);
        if (slot < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && !bl_valid[i])
                    slot = i;
            if (slot < 0) begin
                v.list_full = 1;
                return;
            end
            bl_valid[slot] = 1;
            bl_addr[slot]  = ip;
        end
        bl_time[slot] = now;
        sv_count[s]   = 0;
        v.listed_now  = 1;
    endfunction

    // purge tick: drop stale blacklist entries
    function automatic void purge_stale(logic [31:0] now, ref verdict_t v);
        int removed;
        removed = 0;
        if (purge_r == ALL_ONES)
            return;
        if (32'(now - purge_mark) < purge_r)
            return;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (bl_valid[i] && 32'(now - bl_time[i]) > purge_r) begin
                bl_valid[i] = 0;
                if (removed < 511)
                    removed++;
            end
        purge_mark = now;
        v.purged_count = 9'(removed);
    endfunction

    function automatic verdict_t predict_item(logic [1:0] mode, logic [31:0] ip,
                                              logic [31:0] now);
        verdict_t v;
        v = '{default: 0};
        case (mode)
            MODE_DETECT: count_packet(ip, now, v);
            MODE_FILTER: v.blocked = (ip != 0) && (find_blacklisted(ip) >= 0);
            MODE_PURGE:  purge_stale(now, v);
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        verdict_t want;
        if (!rst_n) begin
            threshold_r = 100;
            window_r    = 1;
            purge_r     = ALL_ONES;
            purge_mark  = 0;
            stats_used  = 0;
            errors      = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                sv_valid[i] = 0;
                bl_valid[i] = 0;
            end
            expected_q.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_THRESHOLD: threshold_r = cfg_wdata;
                    REG_WINDOW:    window_r    = cfg_wdata;
                    REG_PURGE:     purge_r     = cfg_wdata;
                    default: ;
                endcase
            end
            // accepted item beat
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(predict_item(in_ch.mode, in_ch.source_ip,
                                                  in_ch.now_seconds));
            // accepted result beat
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected result beat", $realtime);
                end else begin
                    want = expected_q.pop_front();
                    if (want.blocked !== out_ch.blocked
                        || want.listed_now !== out_ch.listed_now
                        || want.list_full !== out_ch.list_full
                        || want.evicted !== out_ch.evicted
                        || want.purged_count !== out_ch.purged_count) begin
                        errors++;
                        if (errors <= 10)
                            $display("[%0t] mismatch: exp blk=%b lst=%b full=%b ev=%b prg=%0d",
                                     $realtime, want.blocked, want.listed_now,
                                     want.list_full, want.evicted, want.purged_count,
                                     " got blk=%b lst=%b full=%b ev=%b prg=%0d",
                                     out_ch.blocked, out_ch.listed_now,
                                     out_ch.list_full, out_ch.evicted,
                                     out_ch.purged_count);
                    end
                end
            end
        end
    end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top for source_rate_blacklist_engine_core
// Directed corner items, a table fill that forces evictions and a full
// blacklist, a bulk purge, then random traffic over several register
// settings, with random gaps on both channels. The checker scores results.
// ----------------------------------------------------------------------------
module tb;
    import srbe_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [31:0] FILL_BASE = 32'h0A00_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    int          errors;
    int          pending;
    int          cycles;
    bit          calm;
    logic [31:0] clock_s;
    logic [31:0] ip_pool [8];

    srbe_in_if  in_ch ();
    srbe_out_if out_ch ();

    source_rate_blacklist_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    srbe_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, occasionally none
    initial
    begin
        int n;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 17);
            if (n > 0)
            begin
                out_ch.ready <= 0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(negedge clk);
            while (!out_ch.valid) @(negedge clk);
            @(posedge clk);
        end
    end

    // one item beat; returns at the accepting edge with valid still high
    task automatic send_item(logic [1:0] mode, logic [31:0] ip, logic [31:0] now);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1;
        in_ch.mode        <= mode;
        in_ch.source_ip   <= ip;
        in_ch.now_seconds <= now;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
    endtask

    // quiesce, then write all three registers
    task automatic set_regs(logic [31:0] thr, logic [31:0] win, logic [31:0] pur);
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we <= 1; cfg_index <= REG_THRESHOLD; cfg_wdata <= thr;
        @(posedge clk);
        cfg_index <= REG_WINDOW; cfg_wdata <= win;
        @(posedge clk);
        cfg_index <= REG_PURGE; cfg_wdata <= pur;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 15)
            return $urandom;
        return ip_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return MODE_DETECT;
        if (r < 85)
            return MODE_FILTER;
        if (r < 95)
            return MODE_PURGE;
        return MODE_UNUSED;
    endfunction

    initial
    begin
        logic [31:0] thr, win, pur;
        rst_n             = 0;
        cfg_we            = 0;
        cfg_index         = REG_THRESHOLD;
        cfg_wdata         = 0;
        in_ch.valid       = 0;
        in_ch.mode        = MODE_DETECT;
        in_ch.source_ip   = 0;
        in_ch.now_seconds = 0;
        calm              = 0;
        for (int i = 0; i < 8; i++)
            ip_pool[i] = $urandom | 32'h1;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset registers, address zero, unused mode, disabled purge
        send_item(MODE_DETECT, 32'h0, 32'h5);
        send_item(MODE_FILTER, 32'h0, 32'h5);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_PURGE, 32'h1, 32'hFFFF_FFFF);
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'h0);     // time wraps, same window
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'h2);     // window expired
        send_item(MODE_FILTER, 32'hFFFF_FFFF, 32'h2);

        // threshold zero, zero window: lists on any in-window packet
        set_regs(32'h0, 32'h0, ALL_ONES);
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'h2);
        send_item(MODE_FILTER, 32'hFFFF_FFFF, 32'h2);
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'h2);     // refresh
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'h3);     // window restarts

        // max registers
        set_regs(ALL_ONES, ALL_ONES, 32'h0);
        send_item(MODE_DETECT, 32'h8000_0001, 32'h10);
        send_item(MODE_DETECT, 32'h8000_0001, 32'h0F);
        send_item(MODE_PURGE, 32'h0, 32'h3);              // zero lifetime purge
        send_item(MODE_FILTER, 32'hFFFF_FFFF, 32'h3);
        send_item(MODE_PURGE, 32'h0, 32'h3);

        // fill the stats table past capacity, then fill the blacklist
        calm = 1;
        set_regs(32'h1, ALL_ONES, ALL_ONES);
        calm = 0;
        for (int i = 0; i < 270; i++)
        begin
            if (i % 40 == 0)
                calm = ~calm;
            send_item(MODE_DETECT, FILL_BASE + i, 32'd1000);
        end
        send_item(MODE_DETECT, FILL_BASE + 269, 32'd1000);
        for (int i = 1; i < 256; i++)
            send_item(MODE_DETECT, FILL_BASE + i, 32'd1001);
        send_item(MODE_DETECT, 32'hFFFF_FFFF, 32'd1001);  // blacklist already full
        send_item(MODE_DETECT, 32'h8000_0001, 32'd1001);
        send_item(MODE_FILTER, FILL_BASE + 7, 32'd1001);
        calm = 0;

        // bulk purge of the whole blacklist
        set_regs(32'h1, ALL_ONES, 32'd5);
        send_item(MODE_PURGE, 32'h0, 32'd2000);
        send_item(MODE_FILTER, FILL_BASE + 7, 32'd2000);

        // random traffic over several register settings
        clock_s = 32'd3000;
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 4))
                0: thr = 0;
                1: thr = ALL_ONES;
                default: thr = $urandom_range(1, 4);
            endcase
            win = ($urandom_range(0, 5) == 0) ? ALL_ONES : $urandom_range(0, 4);
            pur = ($urandom_range(0, 4) == 0) ? ALL_ONES : $urandom_range(0, 8);
            set_regs(thr, win, pur);
            for (int k = 0; k < 25; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                    calm = ~calm;
                if ($urandom_range(0, 39) == 0)
                    clock_s = $urandom;
                else
                    clock_s = clock_s + $urandom_range(0, 2);
                send_item(pick_mode(), pick_ip(), clock_s);
            end
        end

        // drain and verdict
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
